/* design/path_follow_pid_step_defines.svh */
// Assertion macros for the path-following PID step block.
// Included by design files that carry concurrent checks; no other dependencies.
`ifndef PATH_FOLLOW_PID_STEP_DEFINES_SVH
`define PATH_FOLLOW_PID_STEP_DEFINES_SVH

`ifndef SYNTH
`define PFPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PFPS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define PFPS_ASSERT(label, prop, msg)
`define PFPS_ASSERT_RST(label, prop, msg)
`endif

`endif

/* design/pfps_pkg.sv */
// Types and fixed-point constants for the path-following PID step block.
// No dependencies.
package pfps_pkg;

  localparam int unsigned InW   = 24;
  localparam int unsigned GainW = 16;
  localparam int unsigned ErrW  = 26;
  localparam int unsigned LatW  = 25;
  localparam int unsigned OpAW  = 28;
  localparam int unsigned OpBW  = 17;
  localparam int unsigned ProdW = OpAW + OpBW;
  localparam int unsigned AccW  = 48;
  localparam int unsigned OutW  = 16;

  localparam logic signed [InW-1:0]   Deg0     = 24'sd0;
  localparam logic signed [InW-1:0]   Deg180   = 24'sd46080;
  localparam logic signed [InW-1:0]   Deg90    = 24'sd23040;
  localparam logic signed [InW-1:0]   DegNeg90 = -24'sd23040;
  localparam logic signed [ErrW-1:0]  Deg360   = 26'sd92160;
  localparam logic signed [OpBW-1:0]  WLat     = 17'sd36045;
  localparam logic signed [OpBW-1:0]  WHead    = 17'sd29491;
  localparam logic signed [AccW-1:0]  MixRound = 48'sd32768;
  localparam logic signed [AccW-1:0]  OutRound = 48'sd128;
  localparam logic signed [AccW-1:0]  LimitQ16 = 48'sd6553600;
  localparam logic signed [OutW-1:0]  LimitQ8  = 16'sd25600;

  typedef enum logic [1:0] {
    REG_GAIN_P = 2'd0,
    REG_GAIN_I = 2'd1,
    REG_GAIN_D = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LAT,
    S_MUL_HEAD,
    S_MIX_ADD,
    S_MIX_DONE,
    S_MUL_P,
    S_MUL_I,
    S_MUL_D,
    S_PID_ADD,
    S_CLAMP
  } state_e;

endpackage

/* design/path_follow_pid_step.sv */
// Path-following incremental PID step: heading/lateral error mix, PID increment, clamp.
// Depends on pfps_pkg and path_follow_pid_step_defines.svh.
//
// One control tick enters per input transfer and yields one output transfer. In each
// tick, one shared 28x17 signed multiplier with a registered product and one 48-bit
// accumulator run five products in sequence (two for the 0.55/0.45 error mix, three
// for the P, I and D terms), followed by the clamp to +-100. Input is taken again in
// the cycle after the result is loaded. Input is not taken while a tick is in
// progress; a finished result waits in the output register while the next tick is
// taken, and the sequencer holds in its last step only if that register is still full.
// Gains are written through the plain write port; the user must write them only while
// the block is idle, as the block itself does not enforce this.
`include "path_follow_pid_step_defines.svh"

module path_follow_pid_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target_heading [23:0], current_heading [47:24], offset_x [71:48], offset_y [95:72]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive [15:0]
  output logic [15:0] m_axis_tdata,
  // clamped [0]
  output logic        m_axis_tuser
);
  import pfps_pkg::*;

  state_e state_q, state_d;

  logic [GainW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [ErrW-1:0] herr_q, e_q, e1_q, e2_q;
  logic signed [LatW-1:0] lat_q;
  logic pick_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic m_valid_q;
  logic signed [OutW-1:0] drive_q;
  logic clamped_q;

  logic signed [InW-1:0] tgt, cur, ox, oy;
  logic signed [ErrW-1:0] cur_adj, herr_d;
  logic signed [LatW-1:0] lat_d;
  logic pick_d;
  logic in_xfer, out_free, out_load;
  logic signed [OpAW-1:0] op_a;
  logic signed [OpBW-1:0] op_b;
  logic signed [ProdW-1:0] mul_res;
  logic signed [AccW-1:0] prod_ext, acc_rnd;

  assign tgt = s_axis_tdata[23:0];
  assign cur = s_axis_tdata[47:24];
  assign ox  = s_axis_tdata[71:48];
  assign oy  = s_axis_tdata[95:72];

  always_comb begin
    if (tgt == Deg180 && cur < 0) begin
      cur_adj = ErrW'(cur) + Deg360;
    end else begin
      cur_adj = ErrW'(cur);
    end
    herr_d = ErrW'(tgt) - cur_adj;
    pick_d = 1'b1;
    priority if (tgt == Deg0) begin
      lat_d = LatW'(oy);
    end else if (tgt == Deg180) begin
      lat_d = -LatW'(oy);
    end else if (tgt == Deg90) begin
      lat_d = -LatW'(ox);
    end else if (tgt == DegNeg90) begin
      lat_d = LatW'(ox);
    end else begin
      lat_d  = '0;
      pick_d = 1'b0;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // Sequencer and shared multiplier operand select.
  always_comb begin
    state_d  = state_q;
    op_a     = '0;
    op_b     = '0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_MUL_LAT;
      end
      S_MUL_LAT: begin
        op_a    = OpAW'(lat_q);
        op_b    = WLat;
        state_d = S_MUL_HEAD;
      end
      S_MUL_HEAD: begin
        op_a    = OpAW'(herr_q);
        op_b    = WHead;
        state_d = S_MIX_ADD;
      end
      S_MIX_ADD:  state_d = S_MIX_DONE;
      S_MIX_DONE: state_d = S_MUL_P;
      S_MUL_P: begin
        op_a    = OpAW'(e_q) - OpAW'(e1_q);
        op_b    = OpBW'(signed'({1'b0, gain_p_q}));
        state_d = S_MUL_I;
      end
      S_MUL_I: begin
        op_a    = OpAW'(e_q);
        op_b    = OpBW'(signed'({1'b0, gain_i_q}));
        state_d = S_MUL_D;
      end
      S_MUL_D: begin
        op_a    = OpAW'(e_q) - (OpAW'(e1_q) <<< 1) + OpAW'(e2_q);
        op_b    = OpBW'(signed'({1'b0, gain_d_q}));
        state_d = S_PID_ADD;
      end
      S_PID_ADD:  state_d = S_CLAMP;
      S_CLAMP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  assign mul_res  = op_a * op_b;
  assign prod_ext = AccW'(prod_q);
  assign acc_rnd  = acc_q + OutRound;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      e1_q      <= '0;
      e2_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GAIN_P: gain_p_q <= cfg_data_i;
          REG_GAIN_I: gain_i_q <= cfg_data_i;
          REG_GAIN_D: gain_d_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
        e2_q      <= e1_q;
        e1_q      <= e_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
    if (in_xfer) begin
      herr_q <= herr_d;
      lat_q  <= lat_d;
      pick_q <= pick_d;
      acc_q  <= MixRound;
    end
    unique case (state_q)
      S_MUL_HEAD, S_MIX_ADD, S_MUL_I, S_MUL_D, S_PID_ADD: begin
        acc_q <= acc_q + prod_ext;
      end
      S_MIX_DONE: begin
        acc_q <= '0;
        e_q   <= pick_q ? acc_q[ErrW+15:16] : e1_q;
      end
      default: ;
    endcase
    if (out_load) begin
      if (acc_q > LimitQ16) begin
        drive_q   <= LimitQ8;
        clamped_q <= 1'b1;
      end else if (acc_q < -LimitQ16) begin
        drive_q   <= -LimitQ8;
        clamped_q <= 1'b1;
      end else begin
        drive_q   <= acc_rnd[OutW+7:8];
        clamped_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = drive_q;
  assign m_axis_tuser  = clamped_q;

  `PFPS_ASSERT_RST(a_reset_idle, !rst_ni |=> state_q == S_IDLE && !m_axis_tvalid,
    "block not idle after reset")
  `PFPS_ASSERT(a_start_seq, in_xfer |=> state_q == S_MUL_LAT,
    "input transfer did not start the sequence")
  `PFPS_ASSERT(a_load_valid, out_load |=> m_axis_tvalid,
    "finished tick not presented at output")
  `PFPS_ASSERT(a_clamp_value,
    m_axis_tvalid && m_axis_tuser |-> drive_q == LimitQ8 || drive_q == -LimitQ8,
    "clamped result not at limit")
  `PFPS_ASSERT(a_drive_range,
    m_axis_tvalid |-> drive_q <= LimitQ8 && drive_q >= -LimitQ8,
    "drive outside +-100")

endmodule

/* verif/path_follow_pid_step_test.sv */
// Self-checking testbench for path_follow_pid_step: drives control ticks and gain writes,
// predicts each drive/clamp result in a scoreboard class and compares every output transfer.
// Depends on pfps_pkg and the path_follow_pid_step RTL.
module path_follow_pid_step_test;
  import pfps_pkg::*;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic [15:0] drive;
    logic        clamped;
  } drive_result_t;

  class pid_drive_tracker;
    logic [15:0]   gain_p;
    logic [15:0]   gain_i;
    logic [15:0]   gain_d;
    longint        err_last;
    longint        err_older;
    drive_result_t drive_due_q[$];
    int            errors;

    function new();
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
      err_last = 0;
      err_older = 0;
      errors = 0;
    endfunction

    function void set_gain(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_GAIN_P: gain_p = val;
        REG_GAIN_I: gain_i = val;
        REG_GAIN_D: gain_d = val;
        default: ;
      endcase
    endfunction

    function void note_tick(logic signed [23:0] tgt, logic signed [23:0] cur,
                            logic signed [23:0] ox, logic signed [23:0] oy);
      longint        herr;
      longint        lat;
      longint        err;
      longint        sum;
      longint        lim;
      bit            picked;
      drive_result_t res;
      picked = 1'b1;
      lat = 0;
      lim = longint'(LimitQ16);
      if (tgt == Deg180 && cur < 0) herr = longint'(tgt) - (longint'(cur) + longint'(Deg360));
      else herr = longint'(tgt) - longint'(cur);
      if (tgt == Deg0) lat = longint'(oy);
      else if (tgt == Deg180) lat = -longint'(oy);
      else if (tgt == Deg90) lat = -longint'(ox);
      else if (tgt == DegNeg90) lat = longint'(ox);
      else picked = 1'b0;
      if (picked) begin
        err = (lat * longint'(WLat) + herr * longint'(WHead) + longint'(MixRound)) >>> 16;
      end else begin
        err = err_last;
      end
      sum = longint'(gain_p) * (err - err_last) + longint'(gain_i) * err
          + longint'(gain_d) * (err - 2 * err_last + err_older);
      if (sum > lim) begin
        res.drive = LimitQ8;
        res.clamped = 1'b1;
      end else if (sum < -lim) begin
        res.drive = -LimitQ8;
        res.clamped = 1'b1;
      end else begin
        res.drive = 16'((sum + longint'(OutRound)) >>> 8);
        res.clamped = 1'b0;
      end
      err_older = err_last;
      err_last = err;
      drive_due_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] drive, logic clamped);
      drive_result_t want;
      if (drive_due_q.size() == 0) begin
        $display("%0t: result with none expected, drive %0d clamped %0b",
                 $time, $signed(drive), clamped);
        errors++;
        return;
      end
      want = drive_due_q.pop_front();
      if (drive !== want.drive) begin
        $display("%0t: drive mismatch, expected %0d, got %0d",
                 $time, $signed(want.drive), $signed(drive));
        errors++;
      end
      if (clamped !== want.clamped) begin
        $display("%0t: clamped mismatch, expected %0b, got %0b", $time, want.clamped, clamped);
        errors++;
      end
    endfunction

    function int pending();
      return drive_due_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  pid_drive_tracker tracker = new();
  int unsigned cycles = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;
  bit          rx_steady = 1'b0;
  bit          tx_steady = 1'b0;

  path_follow_pid_step DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial m_axis_tready = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_gap > 0) begin
      m_axis_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata, m_axis_tuser);
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      rx_gap <= rx_steady ? 0 : $urandom_range(0, 18);
    end
  end

  task automatic send_tick(logic signed [23:0] tgt, logic signed [23:0] cur,
                           logic signed [23:0] ox, logic signed [23:0] oy);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {oy, ox, cur, tgt};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_tick(tgt, cur, ox, oy);
  endtask

  task automatic drain_ticks();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_gain(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_gain(idx, val);
  endtask

  function automatic logic signed [23:0] draw_field(int unsigned span);
    int signed v;
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: begin
        v = int'($urandom_range(0, 2 * span)) - int'(span);
        return 24'(v);
      end
    endcase
  endfunction

  function automatic logic signed [23:0] draw_target();
    case ($urandom_range(0, 11))
      0, 1, 2: return Deg0;
      3, 4, 5: return Deg180;
      6, 7:    return Deg90;
      8, 9:    return DegNeg90;
      10:      return Deg180 + 24'($urandom_range(1, 2)) - 24'sd2;
      default: return draw_field(92160);
    endcase
  endfunction

  function automatic logic [15:0] draw_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 768));
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // gains still at reset
    send_tick(Deg0, -24'sd2560, 24'sd0, 24'sd5000);
    send_tick(24'sd1000, 24'sd300, 24'sd7, -24'sd9);
    drain_ticks();

    write_gain(REG_GAIN_P, 16'd256);
    write_gain(REG_GAIN_I, 16'd64);
    write_gain(REG_GAIN_D, 16'd32);
    write_gain(RegSpare, 16'hFFFF);
    send_tick(Deg0, 24'sd1280, 24'sd100, 24'sd2560);
    send_tick(Deg180, -24'sd44800, 24'sd0, 24'sd1000);
    send_tick(Deg180, 24'sd44800, 24'sd0, -24'sd1000);
    send_tick(Deg180, 24'sd0, 24'sd5, 24'sd0);
    send_tick(Deg90, 24'sd20000, 24'sd3000, 24'sd77);
    send_tick(DegNeg90, -24'sd25000, -24'sd3000, 24'sd0);
    send_tick(24'sd12345, 24'sd0, 24'sd0, 24'sd0);
    send_tick(Deg180 + 24'sd1, 24'sd0, 24'sd0, 24'sd0);
    send_tick(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
    send_tick(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_tick(Deg180, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF);
    send_tick(Deg0, 24'sh7FFFFF, 24'sh800000, 24'sh800000);
    send_tick(Deg90, 24'sh800000, 24'sh800000, 24'sh7FFFFF);
    send_tick(DegNeg90, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    drain_ticks();

    // limit boundary: exactly 100 passes, one LSB beyond clamps
    write_gain(REG_GAIN_P, 16'd0);
    write_gain(REG_GAIN_I, 16'd256);
    write_gain(REG_GAIN_D, 16'd0);
    send_tick(Deg0, -24'sd25600, 24'sd0, 24'sd25600);
    send_tick(24'sd777, 24'sd0, 24'sd0, 24'sd0);
    send_tick(Deg0, -24'sd25601, 24'sd0, 24'sd25601);
    send_tick(Deg0, 24'sd25600, 24'sd0, -24'sd25600);
    send_tick(24'sd777, 24'sd0, 24'sd0, 24'sd0);
    send_tick(Deg0, 24'sd25601, 24'sd0, -24'sd25601);

    for (int ph = 0; ph < 7; ph++) begin
      drain_ticks();
      write_gain(REG_GAIN_P, (ph == 0) ? 16'hFFFF : draw_gain());
      write_gain(REG_GAIN_I, (ph == 0) ? 16'hFFFF : draw_gain());
      write_gain(REG_GAIN_D, (ph == 0) ? 16'hFFFF : draw_gain());
      if ($urandom_range(0, 1)) write_gain(RegSpare, 16'($urandom));
      for (int n = 0; n < 150; n++) begin
        send_tick(draw_target(), draw_field(51200), draw_field(25600), draw_field(25600));
        if (ph == 1 && n == 20) rx_hold = 400;
        if (ph == 3 && n == 75) drain_ticks();
      end
    end

    drain_ticks();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
